// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic              op;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic signed [15:0] out_priority;
    logic [1:0]         status;
    logic [4:0]         fill_count;
  } out_word_t;

  // One queue slot as held by a cell.
  typedef struct packed {
    logic               occ;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } slot_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_priority_queue_core.sv =====
// Sorted priority queue: a chain of DEPTH slot cells with a registered result word.
// The result word of an accepted input word is registered and valid in the next cycle.
// Throughput: one operation per cycle unless out_ready holds a result; compares run
// in parallel in every cell and the insert or remove shift happens in the same edge.
// Reset: rst (synchronous) empties the queue and drops any pending result.
`default_nettype none

module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire spq_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output spq_pkg::out_word_t      out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  slot_t     slots [DEPTH];
  logic      belows [DEPTH];
  cell_cmd_t cmd;
  logic      accept;
  logic      full;
  logic      empty;
  logic      enq_ok;
  logic      deq_ok;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  out_word_t res_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = slots[DEPTH-1].occ;
  assign empty    = !slots[0].occ;
  assign enq_ok   = accept && (in_data.op == OP_ENQ) && !full;
  assign deq_ok   = accept && (in_data.op == OP_DEQ) && !empty;

  assign cmd = '{enq: enq_ok, deq: deq_ok,
                 value: in_data.item_value, prio: in_data.item_priority};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_b;
    if (i == 0) begin : g_head
      // Nothing sits ahead of the head, so it takes the new entry whenever it yields.
      assign left_s = '0;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_s = slots[i-1];
      assign left_b = belows[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_body
      assign right_s = slots[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_slot (left_s),
      .left_below(left_b),
      .right_slot(right_s),
      .slot      (slots[i]),
      .below     (belows[i])
    );
  end

  always_comb begin
    count_next = count;
    if (enq_ok) begin
      count_next = count + CW'(1);
    end else if (deq_ok) begin
      count_next = count - CW'(1);
    end
    res_next = '0;
    res_next.fill_count = 5'(count_next);
    if (in_data.op == OP_ENQ) begin
      res_next.status = full ? STATUS_FULL : STATUS_OK;
    end else if (empty) begin
      res_next.status = STATUS_EMPTY;
    end else begin
      res_next.status       = STATUS_OK;
      res_next.out_value    = slots[0].value;
      res_next.out_priority = slots[0].prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: keeps, takes the new entry, or shifts.
`default_nettype none

module spq_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire spq_pkg::cell_cmd_t cmd,
  input  wire spq_pkg::slot_t    left_slot,
  input  wire                    left_below,
  input  wire spq_pkg::slot_t    right_slot,
  output spq_pkg::slot_t         slot,
  output logic                   below
);
  import spq_pkg::*;

  slot_t slot_next;

  // This entry stays ahead of the new one when its priority is greater or equal.
  assign below = slot.occ && (slot.prio >= cmd.prio);

  always_comb begin
    slot_next = slot;
    if (cmd.enq) begin
      if (!below) begin
        if (left_below) begin
          slot_next = '{occ: 1'b1, value: cmd.value, prio: cmd.prio};
        end else begin
          slot_next = left_slot;
        end
      end
    end else if (cmd.deq) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot.value <= slot_next.value;
    slot.prio  <= slot_next.prio;
    if (rst) begin
      slot.occ <= 1'b0;
    end else begin
      slot.occ <= slot_next.occ;
    end
  end

endmodule

`default_nettype wire
